[src/lcfp_pkg.sv]
// Shared types and constants for the LED chase and fade pattern core.
// Holds widths, register indexes, pattern codes and the sequencer states.
// No dependencies.
package lcfp_pkg;

   localparam int CSR_ADDR_W  = 5;
   localparam int CSR_DATA_W  = 32;
   localparam int REQ_TDATA_W = 8;
   localparam int RSP_TDATA_W = 32;
   localparam int PIX_INDEX_W = 6;
   localparam int CHAN_W      = 8;
   localparam int COLOR_W     = 24;
   localparam int COUNT_W     = 7;

   localparam logic [COLOR_W-1:0] COLOR_A_RST     = 24'h000000;
   localparam logic [COLOR_W-1:0] COLOR_B_RST     = 24'hFFFFFF;
   localparam logic [CHAN_W-1:0]  FADE_STEP_RST   = 8'd1;
   localparam logic [CHAN_W-1:0]  HOLD_FRAMES_RST = 8'd1;
   localparam logic [COUNT_W-1:0] LED_COUNT_RST   = 7'd64;

   typedef enum logic [2:0] {
      REG_COLOR_A     = 3'd0,
      REG_COLOR_B     = 3'd1,
      REG_FADE_STEP   = 3'd2,
      REG_HOLD_FRAMES = 3'd3,
      REG_PATTERN     = 3'd4,
      REG_SOFT_FADE   = 3'd5,
      REG_LED_COUNT   = 3'd6
   } csr_index_type;

   typedef enum logic [1:0] {
      PAT_FORWARD = 2'd0,
      PAT_REVERSE = 2'd1,
      PAT_ENDS    = 2'd2,
      PAT_MIDDLE  = 2'd3
   } pattern_type;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_LOAD   = 4'b0010,
      ST_SWEEP  = 4'b0100,
      ST_UPDATE = 4'b1000
   } state_type;

endpackage

[src/led_chase_fade_pattern_core.sv]
// Top level of the LED chase and fade pattern core: register file, pixel store,
// rotate-and-stream sequencer and colour update.
// Depends on lcfp_pkg.
//
//  channel  | direction | ports          | payload
//  ---------+-----------+----------------+-------------------------------------------
//  req      | in        | req_t*         | tdata[0] restart
//  rsp      | out       | rsp_t*         | tdata index/red/green/blue, tlast frame end
//  csr      | in/out    | csr_p*         | seven registers at byte address 4*i
//
//  The pixel store has one read and one write port, so the sweep reads, rotates and
//  writes one pixel a cycle while the result is not stalled.
//  Reset clears the registers, the sequencer and the valid bits of the pixel store.
//  A stalled result holds the sweep; equal colours give no transfer at all.
module led_chase_fade_pattern_core #(
   parameter int MAX_PIXELS = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [lcfp_pkg::REQ_TDATA_W-1:0]    req_tdata,   // [0] restart
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [lcfp_pkg::RSP_TDATA_W-1:0]    rsp_tdata,   // [5:0] pixel_index, [13:6] red,
                                                            // [21:14] green, [29:22] blue
   output logic                                rsp_tlast,   // frame_end
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [lcfp_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [lcfp_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [lcfp_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);

   localparam int PIX_W   = $clog2(MAX_PIXELS);
   localparam int CNT_W   = PIX_W + 1;
   localparam int IDX_W   = lcfp_pkg::PIX_INDEX_W;
   localparam int COLOR_W = lcfp_pkg::COLOR_W;
   localparam int CHAN_W  = lcfp_pkg::CHAN_W;
   localparam int COUNT_W = lcfp_pkg::COUNT_W;

   // registers
   logic [COLOR_W-1:0]    color_a_ff, color_a_in;
   logic [COLOR_W-1:0]    color_b_ff, color_b_in;
   logic [CHAN_W-1:0]     fade_step_ff, fade_step_in;
   logic [CHAN_W-1:0]     hold_frames_ff, hold_frames_in;
   lcfp_pkg::pattern_type pattern_ff, pattern_in;
   logic                  soft_fade_ff, soft_fade_in;
   logic [COUNT_W-1:0]    led_count_ff, led_count_in;

   logic                    csr_wr;
   lcfp_pkg::csr_index_type csr_idx;

   // sequencer and colour state
   lcfp_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [COLOR_W-1:0]  cur_color_ff, cur_color_in;
   logic                heading_ff, heading_in;
   logic [CHAN_W-1:0]   hold_cnt_ff, hold_cnt_in;
   logic [COLOR_W-1:0]  keep_hi_ff, keep_hi_in;
   logic [COLOR_W-1:0]  keep_lo_ff, keep_lo_in;
   logic [COLOR_W-1:0]  prev_ff, prev_in;
   logic [COLOR_W-1:0]  pprev_ff, pprev_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]    rsp_index_ff, rsp_index_in;
   logic [COLOR_W-1:0]  rsp_color_ff, rsp_color_in;
   logic                rsp_last_ff, rsp_last_in;

   // pixel store
   logic [COLOR_W-1:0]    pix_mem_ff [MAX_PIXELS];
   logic [MAX_PIXELS-1:0] vld_ff;
   logic [COLOR_W-1:0]    rd_q_ff;
   logic                  rd_vld_ff;
   logic [PIX_W-1:0]      rd_idx_ff;
   logic                  rd_en;
   logic [PIX_W-1:0]      rd_addr;
   logic                  wr_en;
   logic [PIX_W-1:0]      wr_addr;
   logic [COLOR_W-1:0]    new_px;

   logic [COUNT_W-1:0] count_eff;
   logic [PIX_W-1:0]   last_idx;
   logic [PIX_W-1:0]   mid_idx;
   logic [PIX_W-1:0]   mid_up;
   logic [COLOR_W-1:0] shown;
   logic [COLOR_W-1:0] v_raw;
   logic [COLOR_W-1:0] v_cur;
   logic               inject_hit;
   logic [PIX_W-1:0]   emit_idx;
   logic               advance;
   logic               emit;
   logic [COLOR_W-1:0] target;
   logic [CHAN_W-1:0]  hold_limit;
   logic [CHAN_W:0]    hold_next;

   function automatic logic [7:0] step_chan(input logic [7:0] cur, input logic [7:0] tgt,
                                            input logic [7:0] step);
      logic [7:0] diff;
      diff = 8'd0;
      if (cur > tgt) begin
         diff = cur - tgt;
         return (diff > step) ? cur - step : tgt;
      end
      if (cur < tgt) begin
         diff = tgt - cur;
         return (diff > step) ? cur + step : tgt;
      end
      return cur;
   endfunction

   // register file
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign csr_idx    = lcfp_pkg::csr_index_type'(csr_paddr[4:2]);
   assign csr_pready = 1'b1;

   always_comb begin
      color_a_in     = color_a_ff;
      color_b_in     = color_b_ff;
      fade_step_in   = fade_step_ff;
      hold_frames_in = hold_frames_ff;
      pattern_in     = pattern_ff;
      soft_fade_in   = soft_fade_ff;
      led_count_in   = led_count_ff;
      if (csr_wr) begin
         case (csr_idx)
            lcfp_pkg::REG_COLOR_A:     color_a_in     = csr_pwdata[COLOR_W-1:0];
            lcfp_pkg::REG_COLOR_B:     color_b_in     = csr_pwdata[COLOR_W-1:0];
            lcfp_pkg::REG_FADE_STEP:   fade_step_in   = csr_pwdata[CHAN_W-1:0];
            lcfp_pkg::REG_HOLD_FRAMES: hold_frames_in = csr_pwdata[CHAN_W-1:0];
            lcfp_pkg::REG_PATTERN:     pattern_in     = lcfp_pkg::pattern_type'(csr_pwdata[1:0]);
            lcfp_pkg::REG_SOFT_FADE:   soft_fade_in   = csr_pwdata[0];
            lcfp_pkg::REG_LED_COUNT:   led_count_in   = csr_pwdata[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         lcfp_pkg::REG_COLOR_A:     csr_prdata = 32'(color_a_ff);
         lcfp_pkg::REG_COLOR_B:     csr_prdata = 32'(color_b_ff);
         lcfp_pkg::REG_FADE_STEP:   csr_prdata = 32'(fade_step_ff);
         lcfp_pkg::REG_HOLD_FRAMES: csr_prdata = 32'(hold_frames_ff);
         lcfp_pkg::REG_PATTERN:     csr_prdata = 32'(pattern_ff);
         lcfp_pkg::REG_SOFT_FADE:   csr_prdata = 32'(soft_fade_ff);
         lcfp_pkg::REG_LED_COUNT:   csr_prdata = 32'(led_count_ff);
         default:                   csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         color_a_ff     <= lcfp_pkg::COLOR_A_RST;
         color_b_ff     <= lcfp_pkg::COLOR_B_RST;
         fade_step_ff   <= lcfp_pkg::FADE_STEP_RST;
         hold_frames_ff <= lcfp_pkg::HOLD_FRAMES_RST;
         pattern_ff     <= lcfp_pkg::PAT_FORWARD;
         soft_fade_ff   <= 1'b1;
         led_count_ff   <= lcfp_pkg::LED_COUNT_RST;
      end else begin
         color_a_ff     <= color_a_in;
         color_b_ff     <= color_b_in;
         fade_step_ff   <= fade_step_in;
         hold_frames_ff <= hold_frames_in;
         pattern_ff     <= pattern_in;
         soft_fade_ff   <= soft_fade_in;
         led_count_ff   <= led_count_in;
      end
   end

   // frame geometry and colour on show
   always_comb begin
      if (led_count_ff < COUNT_W'(2)) begin
         count_eff = COUNT_W'(2);
      end else if (led_count_ff > COUNT_W'(MAX_PIXELS)) begin
         count_eff = COUNT_W'(MAX_PIXELS);
      end else begin
         count_eff = led_count_ff;
      end
   end

   assign last_idx = PIX_W'(count_eff - COUNT_W'(1));
   assign mid_idx  = last_idx >> 1;
   assign mid_up   = mid_idx + PIX_W'(1);
   assign shown    = soft_fade_ff ? cur_color_ff : (heading_ff ? color_b_ff : color_a_ff);

   // substitute the injected colour for the entry just read
   always_comb begin
      case (pattern_ff)
         lcfp_pkg::PAT_FORWARD: inject_hit = (rd_idx_ff == '0);
         lcfp_pkg::PAT_REVERSE: inject_hit = (rd_idx_ff == last_idx);
         lcfp_pkg::PAT_ENDS:    inject_hit = (rd_idx_ff == '0) || (rd_idx_ff == last_idx);
         lcfp_pkg::PAT_MIDDLE:  inject_hit = (rd_idx_ff == mid_idx) || (rd_idx_ff == mid_up);
         default:               inject_hit = 1'b0;
      endcase
   end

   assign v_raw    = rd_vld_ff ? rd_q_ff : '0;
   assign v_cur    = inject_hit ? shown : v_raw;
   assign emit_idx = PIX_W'(cnt_ff - CNT_W'(2));
   assign advance  = !rsp_valid_ff || rsp_tready;

   // rotated value of the pixel being sent
   always_comb begin
      case (pattern_ff)
         lcfp_pkg::PAT_FORWARD: new_px = (emit_idx == '0) ? keep_hi_ff : pprev_ff;
         lcfp_pkg::PAT_REVERSE: new_px = (emit_idx == last_idx) ? keep_lo_ff : v_cur;
         lcfp_pkg::PAT_ENDS: begin
            if (emit_idx < mid_idx) begin
               new_px = v_cur;
            end else if (emit_idx <= mid_up) begin
               new_px = shown;
            end else begin
               new_px = pprev_ff;
            end
         end
         lcfp_pkg::PAT_MIDDLE: begin
            if (emit_idx == '0) begin
               new_px = shown;
            end else if (emit_idx <= mid_idx) begin
               new_px = pprev_ff;
            end else if (emit_idx == last_idx) begin
               new_px = shown;
            end else begin
               new_px = v_cur;
            end
         end
         default: new_px = v_cur;
      endcase
   end

   assign target     = heading_ff ? color_a_ff : color_b_ff;
   assign hold_limit = (hold_frames_ff == '0) ? CHAN_W'(1) : hold_frames_ff;
   assign hold_next  = {1'b0, hold_cnt_ff} + (CHAN_W + 1)'(1);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      cur_color_in = cur_color_ff;
      heading_in   = heading_ff;
      hold_cnt_in  = hold_cnt_ff;
      keep_hi_in   = keep_hi_ff;
      keep_lo_in   = keep_lo_ff;
      prev_in      = prev_ff;
      pprev_in     = pprev_ff;
      rsp_index_in = rsp_index_ff;
      rsp_color_in = rsp_color_ff;
      rsp_last_in  = rsp_last_ff;
      req_tready   = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = cnt_ff[PIX_W-1:0];
      wr_en        = 1'b0;
      wr_addr      = emit_idx;
      emit         = 1'b0;
      case (state_ff)
         lcfp_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (req_tdata[0]) begin
                  cur_color_in = color_a_ff;
                  heading_in   = 1'b0;
                  hold_cnt_in  = '0;
               end
               if (color_a_ff != color_b_ff) begin
                  state_in = lcfp_pkg::ST_LOAD;
               end
            end
         end
         lcfp_pkg::ST_LOAD: begin
            rd_en    = 1'b1;
            rd_addr  = last_idx;
            cnt_in   = '0;
            state_in = lcfp_pkg::ST_SWEEP;
         end
         lcfp_pkg::ST_SWEEP: begin
            if (advance) begin
               cnt_in = cnt_ff + CNT_W'(1);
               rd_en  = (cnt_ff <= {1'b0, last_idx});
               if (cnt_ff == '0) begin
                  keep_hi_in = v_cur;
               end else begin
                  prev_in  = v_cur;
                  pprev_in = prev_ff;
               end
               if (cnt_ff == CNT_W'(1)) begin
                  keep_lo_in = v_cur;
               end
               if (cnt_ff >= CNT_W'(2)) begin
                  emit         = 1'b1;
                  wr_en        = 1'b1;
                  rsp_index_in = IDX_W'(emit_idx);
                  rsp_color_in = new_px;
                  rsp_last_in  = (emit_idx == last_idx);
                  if (emit_idx == last_idx) begin
                     state_in = lcfp_pkg::ST_UPDATE;
                  end
               end
            end
         end
         lcfp_pkg::ST_UPDATE: begin
            state_in = lcfp_pkg::ST_IDLE;
            if (soft_fade_ff) begin
               if (cur_color_ff == target) begin
                  heading_in = !heading_ff;
               end else begin
                  cur_color_in = {step_chan(cur_color_ff[23:16], target[23:16], fade_step_ff),
                                  step_chan(cur_color_ff[15:8], target[15:8], fade_step_ff),
                                  step_chan(cur_color_ff[7:0], target[7:0], fade_step_ff)};
               end
            end else begin
               if (hold_next >= {1'b0, hold_limit}) begin
                  hold_cnt_in = '0;
                  heading_in  = !heading_ff;
               end else begin
                  hold_cnt_in = hold_next[CHAN_W-1:0];
               end
            end
         end
         default: state_in = lcfp_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lcfp_pkg::ST_IDLE;
         cnt_ff       <= '0;
         cur_color_ff <= lcfp_pkg::COLOR_A_RST;
         heading_ff   <= 1'b0;
         hold_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         vld_ff       <= '0;
         rd_vld_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         cur_color_ff <= cur_color_in;
         heading_ff   <= heading_in;
         hold_cnt_ff  <= hold_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_vld_ff <= vld_ff[rd_addr];
         end
      end
   end

   always_ff @(posedge clock) begin
      keep_hi_ff   <= keep_hi_in;
      keep_lo_ff   <= keep_lo_in;
      prev_ff      <= prev_in;
      pprev_ff     <= pprev_in;
      rsp_index_ff <= rsp_index_in;
      rsp_color_ff <= rsp_color_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // pixel store: one write and one registered read a cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         pix_mem_ff[wr_addr] <= new_px;
      end
      if (rd_en) begin
         rd_q_ff   <= pix_mem_ff[rd_addr];
         rd_idx_ff <= rd_addr;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {2'b00, rsp_color_ff[7:0], rsp_color_ff[15:8], rsp_color_ff[23:16],
                        rsp_index_ff};

endmodule

[src/lcfp_checker.sv]
// Port-level checker for the LED chase and fade pattern core, with its bind.
// Depends on lcfp_pkg and led_chase_fade_pattern_core.
module lcfp_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [lcfp_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input logic                             rsp_tlast
);

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // no new frame while one is still in flight
   a_busy_mid_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !req_tready)
      else $error("input accepted in the middle of a frame");

   // a frame end leaves a gap before the next frame
   a_gap_after_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> !rsp_tvalid)
      else $error("result straight after frame end");

   // the first pixel never closes a frame
   a_first_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[5:0] == 6'd0) |-> !rsp_tlast)
      else $error("frame ended on pixel zero");

endmodule

bind led_chase_fade_pattern_core lcfp_checker u_lcfp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

[test/lcfp_frame_checker.sv]
`timescale 1ns / 1ps
// Frame checker for the LED chase and fade pattern core: follows register writes and
// frame ticks, predicts every pixel transfer and compares it field by field.
// Depends on lcfp_pkg.
module lcfp_frame_checker #(
   parameter int MAX_PIXELS = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   input  logic [lcfp_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic [lcfp_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                             rsp_tlast,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic                             csr_pready,
   input  logic [lcfp_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [lcfp_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output int                               failures,
   output int                               expected_left
);

   localparam int PIX_INDEX_W = lcfp_pkg::PIX_INDEX_W;
   localparam int CHAN_W      = lcfp_pkg::CHAN_W;
   localparam int COLOR_W     = lcfp_pkg::COLOR_W;
   localparam int COUNT_W     = lcfp_pkg::COUNT_W;

   typedef struct packed {
      logic [PIX_INDEX_W-1:0] index;
      logic [CHAN_W-1:0]      red;
      logic [CHAN_W-1:0]      green;
      logic [CHAN_W-1:0]      blue;
      logic                   frame_end;
   } pixel_beat_type;

   pixel_beat_type        awaited_pixels[$];

   logic [COLOR_W-1:0]    color_a;
   logic [COLOR_W-1:0]    color_b;
   logic [CHAN_W-1:0]     fade_step;
   logic [CHAN_W-1:0]     hold_frames;
   lcfp_pkg::pattern_type chase_pattern;
   logic                  soft_fade;
   logic [COUNT_W-1:0]    led_count;

   logic [COLOR_W-1:0] strip [MAX_PIXELS];
   logic [COLOR_W-1:0] frame_color;
   logic               heading_to_a;
   logic [CHAN_W-1:0]  hold_count;

   initial failures = 0;
   initial expected_left = 0;

   task automatic restore_defaults();
      color_a       = lcfp_pkg::COLOR_A_RST;
      color_b       = lcfp_pkg::COLOR_B_RST;
      fade_step     = lcfp_pkg::FADE_STEP_RST;
      hold_frames   = lcfp_pkg::HOLD_FRAMES_RST;
      chase_pattern = lcfp_pkg::PAT_FORWARD;
      soft_fade     = 1'b1;
      led_count     = lcfp_pkg::LED_COUNT_RST;
      for (int i = 0; i < MAX_PIXELS; i++) strip[i] = '0;
      frame_color   = lcfp_pkg::COLOR_A_RST;
      heading_to_a  = 1'b0;
      hold_count    = '0;
      awaited_pixels.delete();
   endtask

   task automatic rotate_up(input int lo, input int hi);
      logic [COLOR_W-1:0] wrapped;
      wrapped = strip[hi];
      for (int i = hi; i > lo; i--) strip[i] = strip[i-1];
      strip[lo] = wrapped;
   endtask

   task automatic rotate_down(input int lo, input int hi);
      logic [COLOR_W-1:0] wrapped;
      wrapped = strip[lo];
      for (int i = lo; i < hi; i++) strip[i] = strip[i+1];
      strip[hi] = wrapped;
   endtask

   function automatic logic [CHAN_W-1:0] approach(input logic [CHAN_W-1:0] cur,
                                                  input logic [CHAN_W-1:0] tgt,
                                                  input logic [CHAN_W-1:0] step);
      if (cur > tgt) return (cur - tgt > step) ? cur - step : tgt;
      if (cur < tgt) return (tgt - cur > step) ? cur + step : tgt;
      return cur;
   endfunction

   task automatic render_frame(input logic restart);
      int                 n;
      int                 last_px;
      int                 mid_px;
      logic [COLOR_W-1:0] shown;
      logic [COLOR_W-1:0] target;
      pixel_beat_type     beat;
      if (restart) begin
         frame_color  = color_a;
         heading_to_a = 1'b0;
         hold_count   = '0;
      end
      if (color_a == color_b) return;

      n = (led_count < 2) ? 2 : (led_count > MAX_PIXELS) ? MAX_PIXELS : int'(led_count);
      last_px = n - 1;
      mid_px  = last_px / 2;
      shown   = soft_fade ? frame_color : (heading_to_a ? color_b : color_a);

      case (chase_pattern)
         lcfp_pkg::PAT_FORWARD: begin
            strip[0] = shown;
            rotate_up(0, last_px);
         end
         lcfp_pkg::PAT_REVERSE: begin
            strip[last_px] = shown;
            rotate_down(0, last_px);
         end
         lcfp_pkg::PAT_ENDS: begin
            strip[last_px] = shown;
            strip[0]       = shown;
            rotate_down(0, mid_px);
            rotate_up(mid_px + 1, last_px);
         end
         default: begin
            strip[mid_px]     = shown;
            strip[mid_px + 1] = shown;
            rotate_up(0, mid_px);
            rotate_down(mid_px + 1, last_px);
         end
      endcase

      for (int i = 0; i < n; i++) begin
         beat.index     = PIX_INDEX_W'(i);
         beat.red       = strip[i][23:16];
         beat.green     = strip[i][15:8];
         beat.blue      = strip[i][7:0];
         beat.frame_end = (i == last_px);
         awaited_pixels.push_back(beat);
      end

      if (soft_fade) begin
         target = heading_to_a ? color_a : color_b;
         if (frame_color == target) begin
            heading_to_a = ~heading_to_a;
         end else begin
            frame_color = {approach(frame_color[23:16], target[23:16], fade_step),
                           approach(frame_color[15:8],  target[15:8],  fade_step),
                           approach(frame_color[7:0],   target[7:0],   fade_step)};
         end
      end else if (int'(hold_count) + 1 >= ((hold_frames == 0) ? 1 : int'(hold_frames))) begin
         hold_count   = '0;
         heading_to_a = ~heading_to_a;
      end else begin
         hold_count = hold_count + CHAN_W'(1);
      end
   endtask

   task automatic compare_field(input string field, input int want, input int got);
      if (want != got) begin
         failures++;
         $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
      end
   endtask

   always @(posedge clock) begin
      pixel_beat_type want;
      if (reset) begin
         restore_defaults();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[4:2])
               lcfp_pkg::REG_COLOR_A:     color_a       = csr_pwdata[COLOR_W-1:0];
               lcfp_pkg::REG_COLOR_B:     color_b       = csr_pwdata[COLOR_W-1:0];
               lcfp_pkg::REG_FADE_STEP:   fade_step     = csr_pwdata[CHAN_W-1:0];
               lcfp_pkg::REG_HOLD_FRAMES: hold_frames   = csr_pwdata[CHAN_W-1:0];
               lcfp_pkg::REG_PATTERN:
                  chase_pattern = lcfp_pkg::pattern_type'(csr_pwdata[1:0]);
               lcfp_pkg::REG_SOFT_FADE:   soft_fade     = csr_pwdata[0];
               lcfp_pkg::REG_LED_COUNT:   led_count     = csr_pwdata[COUNT_W-1:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (awaited_pixels.size() == 0) begin
               failures++;
               $display("%0t: pixel transfer expected none actual index %0d data %h",
                        $time, rsp_tdata[5:0], rsp_tdata);
            end else begin
               want = awaited_pixels.pop_front();
               compare_field("pixel_index", int'(want.index), int'(rsp_tdata[5:0]));
               compare_field("red",         int'(want.red),   int'(rsp_tdata[13:6]));
               compare_field("green",       int'(want.green), int'(rsp_tdata[21:14]));
               compare_field("blue",        int'(want.blue),  int'(rsp_tdata[29:22]));
               compare_field("frame_end",   int'(want.frame_end), int'(rsp_tlast));
            end
         end
         if (req_tvalid && req_tready) render_frame(req_tdata[0]);
      end
      expected_left <= awaited_pixels.size();
   end

endmodule

[test/tb_led_chase_fade_pattern_core.sv]
`timescale 1ns / 1ps
// Testbench top for the LED chase and fade pattern core: drives frame ticks, register
// writes and result back-pressure, and reports the verdict of lcfp_frame_checker.
// Depends on lcfp_pkg, lcfp_frame_checker and led_chase_fade_pattern_core.
module tb_led_chase_fade_pattern_core;

   localparam int          RANDOM_ITEMS  = 460;
   localparam int          SQUEEZE_PHASE = 3;
   localparam int          LONG_HOLD     = 700;
   localparam int          SETTLE_CYCLES = 80;
   localparam int          STALL_LIMIT   = 4000;
   localparam logic [2:0]  UNUSED_INDEX  = 3'd7;

   logic                             clock       = 1'b0;
   logic                             reset       = 1'b1;
   logic                             req_tvalid  = 1'b0;
   logic                             req_tready;
   logic [lcfp_pkg::REQ_TDATA_W-1:0] req_tdata   = '0;   // [0] restart
   logic                             rsp_tvalid;
   logic                             rsp_tready  = 1'b0;
   logic [lcfp_pkg::RSP_TDATA_W-1:0] rsp_tdata;          // [5:0] index, [13:6] red,
                                                         // [21:14] green, [29:22] blue
   logic                             rsp_tlast;          // frame_end
   logic                             csr_psel    = 1'b0;
   logic                             csr_penable = 1'b0;
   logic                             csr_pwrite  = 1'b0;
   logic [lcfp_pkg::CSR_ADDR_W-1:0]  csr_paddr   = '0;
   logic [lcfp_pkg::CSR_DATA_W-1:0]  csr_pwdata  = '0;
   logic [lcfp_pkg::CSR_DATA_W-1:0]  csr_prdata;
   logic                             csr_pready;

   int                     failures;
   int                     expected_left;
   int                     squeeze_count = 0;
   int                     burst_left    = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   led_chase_fade_pattern_core u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   lcfp_frame_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_pready    (csr_pready),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .failures      (failures),
      .expected_left (expected_left)
   );

   task automatic write_reg(input logic [2:0] index,
                            input logic [lcfp_pkg::CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic offer_frame(input logic restart);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata  <= {{(lcfp_pkg::REQ_TDATA_W-1){1'b0}}, restart};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // drop valid, wait for the last pixel, then let the sequencer settle
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_left != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [lcfp_pkg::CSR_DATA_W-1:0] random_colour();
      logic [lcfp_pkg::CSR_DATA_W-1:0] c;
      c = '0;
      for (int k = 0; k < 3; k++) begin
         case ($urandom_range(0, 3))
            0:       c[8*k +: 8] = 8'h00;
            1:       c[8*k +: 8] = 8'hFF;
            default: c[8*k +: 8] = 8'($urandom);
         endcase
      end
      if ($urandom_range(0, 7) == 0) c[31:24] = 8'($urandom);
      return c;
   endfunction

   initial begin : result_sink
      int segment_left;
      int mode;
      int served;
      segment_left = 0;
      mode         = 0;
      served       = 0;
      forever begin
         @(posedge clock);
         if (squeeze_count > served) begin
            served++;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end
         if (segment_left == 0) begin
            mode         = $urandom_range(0, 3);
            segment_left = $urandom_range(1, 40);
         end
         segment_left--;
         case (mode)
            0:       rsp_tready <= 1'b1;
            1:       rsp_tready <= 1'($urandom_range(0, 1));
            2:       rsp_tready <= (segment_left % 4 == 0);
            default: rsp_tready <= ($urandom_range(0, 9) != 0);
         endcase
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_psel && csr_penable))
            quiet = 0;
         else
            quiet++;
      end
      $display("tb_led_chase_fade_pattern_core NOT OK");
      $finish;
   end

   initial begin : stimulus
      int                              phase;
      int                              items;
      int                              random_sent;
      logic [lcfp_pkg::CSR_DATA_W-1:0] colour_a;
      logic [lcfp_pkg::CSR_DATA_W-1:0] colour_b;
      phase       = 0;
      random_sent = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // defaults: black towards white, full strip, forward chase
      offer_frame(1'b0);
      offer_frame(1'b1);
      drain();

      // shortest strip, full step: reach white, show it twice, turn back
      write_reg(lcfp_pkg::REG_PATTERN, 32'(lcfp_pkg::PAT_REVERSE));
      write_reg(lcfp_pkg::REG_LED_COUNT, 32'd2);
      write_reg(lcfp_pkg::REG_FADE_STEP, 32'd255);
      repeat (3) offer_frame(1'b0);
      drain();

      // counts below the minimum
      write_reg(lcfp_pkg::REG_PATTERN, 32'(lcfp_pkg::PAT_ENDS));
      write_reg(lcfp_pkg::REG_LED_COUNT, 32'd0);
      offer_frame(1'b0);
      drain();
      write_reg(lcfp_pkg::REG_LED_COUNT, 32'd1);
      offer_frame(1'b1);
      drain();

      // masked colours, count above the maximum, write to an unused index
      write_reg(lcfp_pkg::REG_COLOR_A, 32'hFFFF_FFFF);
      write_reg(lcfp_pkg::REG_COLOR_B, 32'h0012_3456);
      write_reg(lcfp_pkg::REG_PATTERN, 32'(lcfp_pkg::PAT_MIDDLE));
      write_reg(lcfp_pkg::REG_LED_COUNT, 32'd127);
      write_reg(UNUSED_INDEX, 32'hFFFF_FFFF);
      offer_frame(1'b1);
      offer_frame(1'b0);
      drain();

      // hold mode with a zero hold, odd count
      write_reg(lcfp_pkg::REG_SOFT_FADE, 32'd0);
      write_reg(lcfp_pkg::REG_HOLD_FRAMES, 32'd0);
      write_reg(lcfp_pkg::REG_LED_COUNT, 32'd3);
      repeat (3) offer_frame(1'b0);
      drain();
      write_reg(lcfp_pkg::REG_HOLD_FRAMES, 32'd5);
      repeat (3) offer_frame(1'b0);
      drain();
      // lower the hold below the running count
      write_reg(lcfp_pkg::REG_HOLD_FRAMES, 32'd2);
      write_reg(lcfp_pkg::REG_PATTERN, 32'(lcfp_pkg::PAT_FORWARD));
      repeat (2) offer_frame(1'b0);
      drain();

      // equal colours give no frame
      write_reg(lcfp_pkg::REG_COLOR_B, 32'h00FF_FFFF);
      offer_frame(1'b1);
      offer_frame(1'b0);
      drain();

      // frozen fade, mode switch back
      colour_a = 32'h0000_FF00;
      colour_b = 32'h00FF_0080;
      write_reg(lcfp_pkg::REG_COLOR_A, colour_a);
      write_reg(lcfp_pkg::REG_COLOR_B, colour_b);
      write_reg(lcfp_pkg::REG_SOFT_FADE, 32'd1);
      write_reg(lcfp_pkg::REG_FADE_STEP, 32'd0);
      write_reg(lcfp_pkg::REG_LED_COUNT, 32'd65);
      write_reg(lcfp_pkg::REG_PATTERN, 32'(lcfp_pkg::PAT_ENDS));
      repeat (2) offer_frame(1'b0);
      drain();
      write_reg(lcfp_pkg::REG_LED_COUNT, 32'd64);
      write_reg(lcfp_pkg::REG_PATTERN, 32'(lcfp_pkg::PAT_MIDDLE));
      write_reg(lcfp_pkg::REG_FADE_STEP, 32'd3);
      offer_frame(1'b0);
      drain();

      while (random_sent < RANDOM_ITEMS) begin
         phase++;
         if (phase == SQUEEZE_PHASE || $urandom_range(0, 2) == 0) colour_a = random_colour();
         if (phase == SQUEEZE_PHASE || $urandom_range(0, 2) == 0) colour_b = random_colour();
         if (phase != SQUEEZE_PHASE && $urandom_range(0, 9) == 0)
            colour_b = colour_a;
         else if (colour_a[lcfp_pkg::COLOR_W-1:0] == colour_b[lcfp_pkg::COLOR_W-1:0])
            colour_b[lcfp_pkg::COLOR_W-1:0] = ~colour_a[lcfp_pkg::COLOR_W-1:0];
         write_reg(lcfp_pkg::REG_COLOR_A, colour_a);
         write_reg(lcfp_pkg::REG_COLOR_B, colour_b);
         if ($urandom_range(0, 1) == 0)
            write_reg(lcfp_pkg::REG_PATTERN, $urandom_range(0, 3));
         if ($urandom_range(0, 2) == 0) write_reg(lcfp_pkg::REG_SOFT_FADE, $urandom);
         if ($urandom_range(0, 2) == 0) begin
            case ($urandom_range(0, 5))
               0:       write_reg(lcfp_pkg::REG_FADE_STEP, 32'd0);
               1:       write_reg(lcfp_pkg::REG_FADE_STEP, 32'd255);
               2:       write_reg(lcfp_pkg::REG_FADE_STEP, $urandom);
               default: write_reg(lcfp_pkg::REG_FADE_STEP, $urandom_range(1, 40));
            endcase
         end
         if ($urandom_range(0, 2) == 0) begin
            case ($urandom_range(0, 5))
               0:       write_reg(lcfp_pkg::REG_HOLD_FRAMES, 32'd255);
               1:       write_reg(lcfp_pkg::REG_HOLD_FRAMES, $urandom_range(0, 255));
               default: write_reg(lcfp_pkg::REG_HOLD_FRAMES, $urandom_range(0, 4));
            endcase
         end
         if ($urandom_range(0, 1) == 0) begin
            case ($urandom_range(0, 19))
               0, 1:    write_reg(lcfp_pkg::REG_LED_COUNT, 32'd64);
               2:       write_reg(lcfp_pkg::REG_LED_COUNT, $urandom_range(0, 1));
               3:       write_reg(lcfp_pkg::REG_LED_COUNT, $urandom_range(65, 127));
               4, 5:    write_reg(lcfp_pkg::REG_LED_COUNT, $urandom_range(13, 63));
               default: write_reg(lcfp_pkg::REG_LED_COUNT, $urandom_range(2, 12));
            endcase
         end
         // hold the result side off while frame ticks keep coming
         if (phase == SQUEEZE_PHASE) squeeze_count <= squeeze_count + 1;
         items = $urandom_range(4, 40);
         repeat (items) begin
            offer_frame($urandom_range(0, 9) == 0);
            random_sent++;
         end
         drain();
      end

      if (failures == 0 && expected_left == 0)
         $display("tb_led_chase_fade_pattern_core OK");
      else
         $display("tb_led_chase_fade_pattern_core NOT OK");
      $finish;
   end

endmodule
